// ===== rtl/core/cfs_pkg.sv =====
// Shared types and constants of the delimited-text field splitter.
package cfs_pkg;

   localparam int unsigned CHAR_WIDTH = 8;
   localparam int unsigned ERR_WIDTH  = 2;

   localparam logic [CHAR_WIDTH-1:0] SEPARATOR_RESET = 8'd44;
   localparam logic [CHAR_WIDTH-1:0] QUOTE_RESET     = 8'd34;

   typedef logic [CHAR_WIDTH-1:0] char_type;

   typedef enum logic [ERR_WIDTH-1:0] {
      ERR_NONE        = 2'd0,
      ERR_BAD_CLOSE   = 2'd1,
      ERR_OPEN_QUOTE  = 2'd2
   } err_type;

   typedef enum logic {
      CSR_SEPARATOR = 1'b0,
      CSR_QUOTE     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_PLAIN  = 3'd1,
      PH_QUOTED = 3'd2,
      PH_QSEEN  = 3'd3,
      PH_SKIP   = 3'd4
   } phase_type;

   typedef struct packed {
      char_type separator_char;
      char_type quote_char;
   } csr_type;

   typedef struct packed {
      logic     char_valid;
      char_type out_char;
      logic     field_end;
      logic     line_end;
      err_type  error_code;
   } rsp_type;

endpackage

// ===== rtl/core/cfs_if.sv =====
// Stream interfaces for the input beats and the result beats.
interface cfs_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] in_byte;

   modport source (output valid, output mode, output in_byte, input ready);
   modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

interface cfs_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [7:0] out_char;
   logic       field_end;
   logic       line_end;
   logic [1:0] error_code;

   modport source (output valid, output char_valid, output out_char, output field_end,
                   output line_end, output error_code, input ready);
   modport sink   (input valid, input char_valid, input out_char, input field_end,
                   input line_end, input error_code, output ready);
endinterface

// ===== rtl/core/cfs_csr.sv =====
// Separator and quote configuration registers.
module cfs_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_en,
   input  logic            csr_index,
   input  logic [7:0]      csr_write_data,
   output cfs_pkg::csr_type cfg
);
   import cfs_pkg::*;

   csr_type cfg_ff;
   csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_SEPARATOR: cfg_in.separator_char = csr_write_data;
            CSR_QUOTE:     cfg_in.quote_char     = csr_write_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.separator_char <= SEPARATOR_RESET;
         cfg_ff.quote_char     <= QUOTE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ===== rtl/core/cfs_parser.sv =====
// Field and quote state machine that decides one beat per cycle while beats are accepted.
module cfs_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             mode,
   input  logic [7:0]       in_byte,
   input  cfs_pkg::csr_type cfg,
   output cfs_pkg::rsp_type result
);
   import cfs_pkg::*;

   phase_type phase_ff;
   phase_type phase_in;
   logic      field_done_ff;
   logic      field_done_in;
   logic      is_sep;
   logic      is_quote;

   assign is_sep   = (in_byte == cfg.separator_char);
   assign is_quote = (in_byte == cfg.quote_char);

   // Next state.
   always_comb begin
      phase_in      = phase_ff;
      field_done_in = field_done_ff;
      if (accept) begin
         if (mode) begin
            phase_in      = PH_START;
            field_done_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_PLAIN: begin
                  if (is_sep) begin
                     phase_in      = PH_START;
                     field_done_in = 1'b1;
                  end
               end
               PH_QUOTED: begin
                  if (is_quote) begin
                     phase_in = PH_QSEEN;
                  end
               end
               PH_QSEEN: begin
                  if (is_quote) begin
                     phase_in = PH_QUOTED;
                  end else if (is_sep) begin
                     phase_in      = PH_START;
                     field_done_in = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_SKIP: phase_in = PH_SKIP;
               default: begin
                  if (is_quote) begin
                     phase_in = PH_QUOTED;
                  end else if (is_sep) begin
                     phase_in      = PH_START;
                     field_done_in = 1'b1;
                  end else begin
                     phase_in = PH_PLAIN;
                  end
               end
            endcase
         end
      end
   end

   // Result of the current beat.
   always_comb begin
      result            = '0;
      result.error_code = ERR_NONE;
      if (mode) begin
         result.line_end = 1'b1;
         case (phase_ff)
            PH_PLAIN, PH_QSEEN: result.field_end  = 1'b1;
            PH_QUOTED:          result.error_code = ERR_OPEN_QUOTE;
            PH_SKIP:            result.error_code = ERR_BAD_CLOSE;
            default:            result.field_end  = ~field_done_ff;
         endcase
      end else begin
         case (phase_ff)
            PH_PLAIN: begin
               if (is_sep) begin
                  result.field_end = 1'b1;
               end else begin
                  result.char_valid = 1'b1;
                  result.out_char   = in_byte;
               end
            end
            PH_QUOTED: begin
               if (!is_quote) begin
                  result.char_valid = 1'b1;
                  result.out_char   = in_byte;
               end
            end
            PH_QSEEN: begin
               if (is_quote) begin
                  result.char_valid = 1'b1;
                  result.out_char   = in_byte;
               end else if (is_sep) begin
                  result.field_end = 1'b1;
               end else begin
                  result.error_code = ERR_BAD_CLOSE;
               end
            end
            PH_SKIP: result = '0;
            default: begin
               if (is_sep && !is_quote) begin
                  result.field_end = 1'b1;
               end else if (!is_quote) begin
                  result.char_valid = 1'b1;
                  result.out_char   = in_byte;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         field_done_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         field_done_ff <= field_done_in;
      end
   end
endmodule

// ===== rtl/core/cfs_rsp_stage.sv =====
// Result register that holds one beat until the sink takes it.
module cfs_rsp_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cfs_pkg::rsp_type result,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cfs_pkg::rsp_type rsp_data
);
   import cfs_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   logic    load;

   assign req_ready = ~valid_ff | rsp_ready;
   assign load      = req_valid & req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

// ===== rtl/core/csv_field_splitter_unit.sv =====
// Top level of the delimited-text field splitter.
//
//   Channel   Direction  Payload
//   req_bus   in         mode, in_byte
//   rsp_bus   out        char_valid, out_char, field_end, line_end, error_code
//   csr_*     in         write enable, register index, write data
//
// A new beat is accepted in every cycle unless a stalled result waits in the result
// register, and its result appears there in the cycle after it is accepted. Reset is
// synchronous and returns the phase to field start and the configuration to its
// defaults. A stalled result holds in the result register, and a new beat is still
// accepted in the cycle the waiting result is taken.
module csv_field_splitter_unit (
   input  logic       clock,
   input  logic       reset,
   cfs_req_if.sink    req_bus,
   cfs_rsp_if.source  rsp_bus,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);
   import cfs_pkg::*;

   csr_type cfg;
   rsp_type result;
   rsp_type rsp_data;
   logic    req_ready;
   logic    accept;

   assign accept        = req_bus.valid & req_ready;
   assign req_bus.ready = req_ready;

   cfs_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   cfs_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .mode    (req_bus.mode),
      .in_byte (req_bus.in_byte),
      .cfg     (cfg),
      .result  (result)
   );

   cfs_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .result    (result),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_bus.char_valid = rsp_data.char_valid;
   assign rsp_bus.out_char   = rsp_data.out_char;
   assign rsp_bus.field_end  = rsp_data.field_end;
   assign rsp_bus.line_end   = rsp_data.line_end;
   assign rsp_bus.error_code = rsp_data.error_code;
endmodule

// ===== tb/sv/csv_field_splitter_unit_tb.sv =====
// Self-checking testbench for the delimited-text field splitter: random lines, stalls, checks.
`timescale 1ns / 100ps

module csv_field_splitter_unit_tb;
   import cfs_pkg::*;

   localparam logic MODE_TEXT = 1'b0;
   localparam logic MODE_EOL  = 1'b1;

   localparam int IDLE_LIMIT      = 1000;
   localparam int HOLD_CYCLES     = 80;
   localparam int BEATS_PER_PHASE = 70;

   class field_split_tracker;
      char_type  separator;
      char_type  quote;
      phase_type phase;
      bit        field_closed;
      rsp_type   pending_results[$];
      int        mismatches;
      int        results_seen;
      int        fields_seen;
      int        errors_seen;

      function new();
         separator    = SEPARATOR_RESET;
         quote        = QUOTE_RESET;
         phase        = PH_START;
         field_closed = 1'b0;
         mismatches   = 0;
         results_seen = 0;
         fields_seen  = 0;
         errors_seen  = 0;
      endfunction

      function void set_register(csr_index_type idx, char_type value);
         if (idx == CSR_SEPARATOR) begin
            separator = value;
         end else begin
            quote = value;
         end
      endfunction

      function void close_field(ref rsp_type r);
         r.field_end  = 1'b1;
         phase        = PH_START;
         field_closed = 1'b1;
      endfunction

      function void take_byte(logic mode, char_type b);
         rsp_type r;
         r = '0;
         if (mode == MODE_EOL) begin
            case (phase)
               PH_PLAIN, PH_QSEEN: begin
                  r.field_end = 1'b1;
               end
               PH_QUOTED: begin
                  r.error_code = ERR_OPEN_QUOTE;
               end
               PH_SKIP: begin
                  r.error_code = ERR_BAD_CLOSE;
               end
               default: begin
                  r.field_end = !field_closed;
               end
            endcase
            r.line_end   = 1'b1;
            phase        = PH_START;
            field_closed = 1'b0;
         end else begin
            case (phase)
               PH_PLAIN: begin
                  if (b == separator) begin
                     close_field(r);
                  end else begin
                     r.char_valid = 1'b1;
                     r.out_char   = b;
                  end
               end
               PH_QUOTED: begin
                  if (b == quote) begin
                     phase = PH_QSEEN;
                  end else begin
                     r.char_valid = 1'b1;
                     r.out_char   = b;
                  end
               end
               PH_QSEEN: begin
                  if (b == quote) begin
                     r.char_valid = 1'b1;
                     r.out_char   = b;
                     phase        = PH_QUOTED;
                  end else if (b == separator) begin
                     close_field(r);
                  end else begin
                     r.error_code = ERR_BAD_CLOSE;
                     phase        = PH_SKIP;
                  end
               end
               PH_SKIP: begin
               end
               default: begin
                  if (b == quote) begin
                     phase = PH_QUOTED;
                  end else if (b == separator) begin
                     close_field(r);
                  end else begin
                     r.char_valid = 1'b1;
                     r.out_char   = b;
                     phase        = PH_PLAIN;
                  end
               end
            endcase
         end
         pending_results.insert(pending_results.size(), r);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task compare_result(rsp_type got);
         rsp_type exp;
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
         end
         exp = pending_results.pop_front();
         fields_seen += exp.field_end;
         if (exp.error_code != ERR_NONE) errors_seen++;
         if (got.char_valid !== exp.char_valid)
            report_mismatch($sformatf("result %0d char_valid %0b, expected %0b",
                                      results_seen, got.char_valid, exp.char_valid));
         if (got.out_char !== exp.out_char)
            report_mismatch($sformatf("result %0d out_char %02h, expected %02h",
                                      results_seen, got.out_char, exp.out_char));
         if (got.field_end !== exp.field_end)
            report_mismatch($sformatf("result %0d field_end %0b, expected %0b",
                                      results_seen, got.field_end, exp.field_end));
         if (got.line_end !== exp.line_end)
            report_mismatch($sformatf("result %0d line_end %0b, expected %0b",
                                      results_seen, got.line_end, exp.line_end));
         if (got.error_code !== exp.error_code)
            report_mismatch($sformatf("result %0d error_code %0d, expected %0d",
                                      results_seen, got.error_code, exp.error_code));
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       csr_write_en;
   logic       csr_index;
   logic [7:0] csr_write_data;

   cfs_req_if req_bus ();
   cfs_rsp_if rsp_bus ();

   field_split_tracker tracker = new();

   bit steady;
   bit hold_request;
   int beats_sent;
   int lines_sent;
   int settings_used;
   int idle_cycles;

   csv_field_splitter_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic char_type content_byte();
      char_type b;
      do b = char_type'($urandom_range(0, 255));
      while (b == tracker.separator || b == tracker.quote);
      return b;
   endfunction

   function automatic char_type noise_byte();
      int roll;
      roll = $urandom_range(0, 3);
      if (roll == 0) return tracker.separator;
      if (roll == 1) return tracker.quote;
      return char_type'($urandom_range(0, 255));
   endfunction

   task automatic send_beat(logic mode, char_type data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= mode;
      req_bus.in_byte <= data;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_byte(mode, data);
      beats_sent++;
      if (mode == MODE_EOL) lines_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(MODE_TEXT, char_type'(s[i]));
   endtask

   task automatic end_line();
      send_beat(MODE_EOL, char_type'($urandom_range(0, 255)));
   endtask

   task automatic send_line();
      int fields;
      int kind;
      int len;
      fields = $urandom_range(0, 4);
      for (int f = 0; f < fields; f++) begin
         if (f > 0) send_beat(MODE_TEXT, tracker.separator);
         kind = $urandom_range(0, 9);
         len  = $urandom_range(1, 4);
         if (kind >= 2 && kind <= 5) begin
            send_beat(MODE_TEXT, content_byte());
            for (int i = 1; i < len; i++) begin
               send_beat(MODE_TEXT, ($urandom_range(0, 9) == 0) ? tracker.quote : content_byte());
            end
         end else if (kind > 5) begin
            send_beat(MODE_TEXT, tracker.quote);
            for (int i = 1; i < len; i++) begin
               if ($urandom_range(0, 4) == 0) begin
                  send_beat(MODE_TEXT, tracker.quote);
                  send_beat(MODE_TEXT, tracker.quote);
               end else begin
                  send_beat(MODE_TEXT, content_byte());
               end
            end
            send_beat(MODE_TEXT, tracker.quote);
         end
      end
      if ($urandom_range(0, 5) == 0) send_beat(MODE_TEXT, tracker.separator);
      end_line();
   endtask

   task automatic send_broken_line();
      int len;
      len = $urandom_range(1, 8);
      case ($urandom_range(0, 2))
         0: begin
            send_beat(MODE_TEXT, tracker.quote);
            send_beat(MODE_TEXT, content_byte());
            send_beat(MODE_TEXT, tracker.quote);
            send_beat(MODE_TEXT, content_byte());
            for (int i = 1; i < len; i++) send_beat(MODE_TEXT, noise_byte());
         end
         1: begin
            send_beat(MODE_TEXT, tracker.quote);
            for (int i = 1; i < len; i++) send_beat(MODE_TEXT, content_byte());
         end
         default: begin
            for (int i = 0; i < len; i++) send_beat(MODE_TEXT, noise_byte());
         end
      endcase
      end_line();
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_registers(char_type sep, char_type quo);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_SEPARATOR;
      csr_write_data <= sep;
      @(posedge clock);
      csr_index      <= CSR_QUOTE;
      csr_write_data <= quo;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      tracker.set_register(CSR_SEPARATOR, sep);
      tracker.set_register(CSR_QUOTE, quo);
      settings_used++;
   endtask

   initial begin
      int stall;
      rsp_type got;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            stall        = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.char_valid = rsp_bus.char_valid;
         got.out_char   = rsp_bus.out_char;
         got.field_end  = rsp_bus.field_end;
         got.line_end   = rsp_bus.line_end;
         got.error_code = err_type'(rsp_bus.error_code);
         tracker.compare_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("csv_field_splitter_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      char_type seps[6];
      char_type quos[6];
      int phase_start;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.mode    <= MODE_TEXT;
      req_bus.in_byte <= '0;
      csr_write_en    <= 1'b0;
      csr_index       <= CSR_SEPARATOR;
      csr_write_data  <= '0;
      steady          = 1'b0;
      hold_request    = 1'b0;
      beats_sent      = 0;
      lines_sent      = 0;
      settings_used   = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines under the reset settings.
      send_beat(MODE_EOL, 8'hFF);
      send_beat(MODE_TEXT, 8'h00);
      send_beat(MODE_TEXT, 8'hFF);
      send_text("\",");
      send_beat(MODE_EOL, 8'h00);
      send_text("\"x\"\"y\",z");
      end_line();
      send_text(",\"");
      end_line();
      send_text("\"\"qr");
      end_line();
      send_text("\"k\"");
      end_line();

      seps[0] = 8'h00;            quos[0] = 8'hFF;
      seps[1] = 8'hFF;            quos[1] = 8'h00;
      seps[2] = 8'h3B;            quos[2] = 8'h27;
      seps[3] = char_type'($urandom_range(0, 255));
      quos[3] = seps[3];
      seps[4] = char_type'($urandom_range(0, 255));
      quos[4] = char_type'($urandom_range(0, 255));
      seps[5] = SEPARATOR_RESET;  quos[5] = QUOTE_RESET;

      for (int p = 0; p < 6; p++) begin
         wait_idle();
         program_registers(seps[p], quos[p]);
         steady       = (p == 3);
         hold_request = (p == 1);
         phase_start  = beats_sent;
         while (beats_sent - phase_start < BEATS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 20) begin
               send_broken_line();
            end else begin
               send_line();
            end
         end
      end

      wait_idle();
      repeat (5) @(posedge clock);
      if (tracker.pending_results.size() != 0)
         tracker.report_mismatch($sformatf("%0d expected results never arrived",
                                           tracker.pending_results.size()));
      $display("Sent %0d beats in %0d lines across %0d separator/quote settings.",
               beats_sent, lines_sent, settings_used);
      $display("Checked %0d results: %0d field ends, %0d flagged errors, %0d mismatches.",
               tracker.results_seen, tracker.fields_seen, tracker.errors_seen,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("csv_field_splitter_unit verification clean");
      end else begin
         $display("csv_field_splitter_unit verification failed");
      end
      $finish;
   end

endmodule
